// ===== sv/piu_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker package
// Shared widths, configuration codes, the batch record passed from the front
// stage to the lanes and drain, and small helper functions.
// ----------------------------------------------------------------------------
package piu_pkg;

   localparam int WORD_W          = 64;
   localparam int VALUE_W         = 16;
   localparam int STREAM_W        = WORD_W + VALUE_W;
   localparam int LANES           = 16;
   localparam int LANE_IDX_W      = $clog2(LANES);
   localparam int COUNT_W         = $clog2(LANES + 1);
   localparam int SECTION_ENTRIES = 4096;
   localparam int ENTRY_CNT_W     = $clog2(SECTION_ENTRIES + 1);
   localparam int NUM_W           = 12;
   localparam int WIDTH_W         = 5;
   localparam int CARRY_CNT_W     = 5;
   localparam int TOTAL_W         = 7;
   localparam int POS_W           = 9;
   localparam int SHIFT_W         = 8;
   localparam int MIN_WIDTH       = 4;
   localparam int MAX_WIDTH       = 16;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [WIDTH_W-1:0] RESET_WIDTH  = WIDTH_W'(MIN_WIDTH);
   localparam logic               LAYOUT_SPAN   = 1'b0;
   localparam logic               LAYOUT_PADDED = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENTRY_WIDTH = 1'b0,
      CSR_LAYOUT_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [STREAM_W-1:0]    stream;
      logic [WIDTH_W-1:0]     width;
      logic [COUNT_W-1:0]     count;
      logic [ENTRY_CNT_W-1:0] base;
   } batch_type;

   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] raw);
      logic [WIDTH_W-1:0] result;
      if (raw < WIDTH_W'(MIN_WIDTH)) begin
         result = WIDTH_W'(MIN_WIDTH);
      end else if (raw > WIDTH_W'(MAX_WIDTH)) begin
         result = WIDTH_W'(MAX_WIDTH);
      end else begin
         result = raw;
      end
      return result;
   endfunction

   function automatic logic [VALUE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
      logic [VALUE_W-1:0] mask;
      for (int j = 0; j < VALUE_W; j++) begin
         mask[j] = (WIDTH_W'(j) < w);
      end
      return mask;
   endfunction

endpackage

// ===== sv/piu_front.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker front stage
// Joins leftover bits with the incoming word, works out how many entries the
// word yields, updates the leftover bits and section counter, and registers
// the joined bit stream as a batch for the lanes.
// ----------------------------------------------------------------------------
module piu_front import piu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic                batch_move,
   input  logic [WORD_W-1:0]   packed_word,
   input  logic                first_word,
   input  logic [WIDTH_W-1:0]  width,
   input  logic                layout,
   output logic                batch_valid,
   output batch_type           batch
);

   logic [VALUE_W-1:0]     carry_bits_ff, carry_bits_in;
   logic [CARRY_CNT_W-1:0] carry_count_ff, carry_count_in;
   logic [ENTRY_CNT_W-1:0] entries_done_ff, entries_done_in;
   logic                   batch_valid_ff, batch_valid_in;
   batch_type              batch_ff, batch_in;

   logic                   padded;
   logic [VALUE_W-1:0]     carry_bits_eff;
   logic [CARRY_CNT_W-1:0] carry_count_eff;
   logic [ENTRY_CNT_W-1:0] entries_done_eff;
   logic [TOTAL_W-1:0]     total;
   logic [STREAM_W-1:0]    stream;
   logic [STREAM_W-1:0]    stream_rest;
   logic [LANES-1:0]       fits;
   logic [COUNT_W-1:0]     fit_count;
   logic [ENTRY_CNT_W-1:0] remaining;
   logic [COUNT_W-1:0]     emit_count;
   logic [POS_W-1:0]       pos;
   logic [POS_W-1:0]       left;
   logic [ENTRY_CNT_W-1:0] entries_next;
   logic                   section_full;

   always_comb begin
      padded           = (layout == LAYOUT_PADDED);
      carry_bits_eff   = (first_word || padded) ? '0 : carry_bits_ff;
      carry_count_eff  = (first_word || padded) ? '0 : carry_count_ff;
      entries_done_eff = first_word ? '0 : entries_done_ff;
      total            = TOTAL_W'(carry_count_eff) + TOTAL_W'(WORD_W);

      // Leftover bits sit below the word in the joined stream.
      stream = ({{VALUE_W{1'b0}}, packed_word} << carry_count_eff)
             | {{WORD_W{1'b0}}, carry_bits_eff};

      for (int i = 0; i < LANES; i++) begin
         fits[i] = (POS_W'(i + 1) * POS_W'(width)) <= POS_W'(total);
      end
      fit_count = COUNT_W'($countones(fits));

      if (entries_done_eff >= ENTRY_CNT_W'(SECTION_ENTRIES)) begin
         remaining = '0;
      end else begin
         remaining = ENTRY_CNT_W'(SECTION_ENTRIES) - entries_done_eff;
      end
      emit_count = (remaining < ENTRY_CNT_W'(fit_count)) ? COUNT_W'(remaining) : fit_count;

      pos          = POS_W'(emit_count) * POS_W'(width);
      left         = POS_W'(total) - pos;
      entries_next = entries_done_eff + ENTRY_CNT_W'(emit_count);
      section_full = entries_next >= ENTRY_CNT_W'(SECTION_ENTRIES);
      stream_rest  = stream >> pos;
   end

   always_comb begin
      carry_bits_in   = carry_bits_ff;
      carry_count_in  = carry_count_ff;
      entries_done_in = entries_done_ff;
      batch_valid_in  = batch_valid_ff;
      batch_in        = batch_ff;
      if (req_accept) begin
         entries_done_in = entries_next;
         if (padded || section_full) begin
            carry_bits_in  = '0;
            carry_count_in = '0;
         end else begin
            carry_bits_in  = stream_rest[VALUE_W-1:0];
            carry_count_in = CARRY_CNT_W'(left);
         end
         batch_valid_in = (emit_count != '0);
         batch_in.stream = stream;
         batch_in.width  = width;
         batch_in.count  = emit_count;
         batch_in.base   = entries_done_eff;
      end else if (batch_move) begin
         batch_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff   <= '0;
         carry_count_ff  <= '0;
         entries_done_ff <= '0;
         batch_valid_ff  <= 1'b0;
      end else begin
         carry_bits_ff   <= carry_bits_in;
         carry_count_ff  <= carry_count_in;
         entries_done_ff <= entries_done_in;
         batch_valid_ff  <= batch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
   end

   assign batch_valid = batch_valid_ff;
   assign batch       = batch_ff;

endmodule

// ===== sv/piu_lane.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker lane
// Extracts one fixed-width entry from the joined bit stream at the offset
// given by this lane's position.
// ----------------------------------------------------------------------------
module piu_lane import piu_pkg::*; (
   input  logic [STREAM_W-1:0]   stream,
   input  logic [WIDTH_W-1:0]    width,
   input  logic [LANE_IDX_W-1:0] lane_index,
   output logic [VALUE_W-1:0]    value
);

   logic [SHIFT_W-1:0]  offset;
   logic [STREAM_W-1:0] shifted;

   always_comb begin
      offset  = SHIFT_W'(lane_index) * SHIFT_W'(width);
      shifted = stream >> offset;
      value   = shifted[VALUE_W-1:0] & width_mask(width);
   end

endmodule

// ===== sv/piu_drain.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker drain
// Captures the entries found by all lanes for one word and hands them out
// in order, one per cycle while rsp_ready is high, with their section position and markers.
// ----------------------------------------------------------------------------
module piu_drain import piu_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [COUNT_W-1:0]            load_count,
   input  logic [ENTRY_CNT_W-1:0]        load_base,
   input  logic [LANES-1:0][VALUE_W-1:0] lane_values,
   input  logic                          rsp_ready,
   output logic                          drain_free,
   output logic                          rsp_valid,
   output logic [NUM_W-1:0]              rsp_entry_number,
   output logic [VALUE_W-1:0]            rsp_entry_value,
   output logic                          rsp_last_of_word,
   output logic                          rsp_section_done
);

   logic                          valid_ff, valid_in;
   logic [LANES-1:0][VALUE_W-1:0] values_ff, values_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [LANE_IDX_W-1:0]         idx_ff, idx_in;
   logic [ENTRY_CNT_W-1:0]        num_ff, num_in;
   logic                          last;
   logic                          take;

   always_comb begin
      last = (COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff;
      take = valid_ff && rsp_ready;
      drain_free = !valid_ff || (take && last);

      valid_in  = valid_ff;
      values_in = values_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      num_in    = num_ff;
      if (load) begin
         valid_in  = 1'b1;
         values_in = lane_values;
         count_in  = load_count;
         idx_in    = '0;
         num_in    = load_base;
      end else if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + LANE_IDX_W'(1);
            num_in = num_ff + ENTRY_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      values_ff <= values_in;
      count_ff  <= count_in;
      idx_ff    <= idx_in;
      num_ff    <= num_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_entry_number = NUM_W'(num_ff);
   assign rsp_entry_value  = values_ff[idx_ff];
   assign rsp_last_of_word = last;
   assign rsp_section_done = (num_ff == ENTRY_CNT_W'(SECTION_ENTRIES - 1));

endmodule

// ===== sv/packed_index_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker
// Unpacks fixed-width palette indices from 64-bit words, LSB first, in padded
// or word-spanning layout, one result transaction per index.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the req_ channel; each yields up to 16 index transactions on
// the rsp_ channel, in order, with the last one of a word flagged. A word with
// req_first_word set starts a new section; once 4096 entries are out, words
// give no results until the next first word. csr_ writes set the entry width
// (index 0) and the layout (index 1) and are taken every cycle; write them
// only while the unit is idle.
// A taken word passes the front stage register, then the lane capture register,
// before its first result appears.
// Throughput: the drain hands out one index per cycle while rsp_ready is high,
// so a word holds the result port until its entries, at most 16 (at width 4),
// are out. While the drain works, the next word is taken and waits in the front
// stage, so words follow each other without gaps.
// Words that give no result are taken without filling the front stage.
// Reset clears the leftover bits, the section counter and both stages and
// sets width 4 in padded layout. If the receiver stalls, the current result
// holds, and at most one more word with results is taken before req_ready
// falls; no word at all is taken while it is low.
// ----------------------------------------------------------------------------
module packed_index_unpacker_unit import piu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [WORD_W-1:0]      req_packed_word,
   input  logic                   req_first_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [NUM_W-1:0]       rsp_entry_number,
   output logic [VALUE_W-1:0]     rsp_entry_value,
   output logic                   rsp_last_of_word,
   output logic                   rsp_section_done,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WIDTH_W-1:0]     csr_wdata
);

   logic [WIDTH_W-1:0]            entry_width_ff, entry_width_in;
   logic                          layout_mode_ff, layout_mode_in;
   logic [WIDTH_W-1:0]            used_width;
   logic                          req_accept;
   logic                          batch_valid;
   batch_type                     batch;
   logic                          batch_move;
   logic                          drain_free;
   logic [LANES-1:0][VALUE_W-1:0] lane_values;

   assign csr_ready = 1'b1;

   always_comb begin
      entry_width_in = entry_width_ff;
      layout_mode_in = layout_mode_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENTRY_WIDTH: entry_width_in = csr_wdata;
            CSR_LAYOUT_MODE: layout_mode_in = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_width_ff <= RESET_WIDTH;
         layout_mode_ff <= LAYOUT_PADDED;
      end else begin
         entry_width_ff <= entry_width_in;
         layout_mode_ff <= layout_mode_in;
      end
   end

   assign used_width = clamp_width(entry_width_ff);
   assign batch_move = batch_valid && drain_free;
   assign req_ready  = !batch_valid || drain_free;
   assign req_accept = req_valid && req_ready;

   piu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .batch_move  (batch_move),
      .packed_word (req_packed_word),
      .first_word  (req_first_word),
      .width       (used_width),
      .layout      (layout_mode_ff),
      .batch_valid (batch_valid),
      .batch       (batch)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      piu_lane u_lane (
         .stream     (batch.stream),
         .width      (batch.width),
         .lane_index (LANE_IDX_W'(g)),
         .value      (lane_values[g])
      );
   end

   piu_drain u_drain (
      .clock            (clock),
      .reset            (reset),
      .load             (batch_move),
      .load_count       (batch.count),
      .load_base        (batch.base),
      .lane_values      (lane_values),
      .rsp_ready        (rsp_ready),
      .drain_free       (drain_free),
      .rsp_valid        (rsp_valid),
      .rsp_entry_number (rsp_entry_number),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_last_of_word (rsp_last_of_word),
      .rsp_section_done (rsp_section_done)
   );

   // The final entry of a section is always the last one its word produces.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_section_done |-> rsp_last_of_word)
      else $error("section end not marked as last of word");

   // A staged batch always carries between one and LANES entries.
   a_batch_count: assert property (@(posedge clock) disable iff (reset)
      batch_valid |-> (batch.count != '0) && (batch.count <= COUNT_W'(LANES)))
      else $error("staged batch has an invalid entry count");

   // Within a word, entry numbers follow each other without a gap.
   a_number_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_word |=>
         rsp_valid && (rsp_entry_number == $past(rsp_entry_number) + NUM_W'(1)))
      else $error("entry number skipped within a word");

endmodule

// ===== tb/sv/tb_packed_index_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// Packed index unpacker testbench
// Drives 64-bit words through the unpacker in both layouts and across the
// legal and clamped entry widths, lets a scoreboard class work out every index
// transaction each accepted word should give, and compares the result stream
// in order. A directed opening covers bit patterns, width clamping, leftover
// bits across width and layout changes and a full section; random phases with
// bursty input and a stalling receiver follow.
// ----------------------------------------------------------------------------
module tb_packed_index_unpacker_unit;
   import piu_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_WORDS = 220;
   localparam int SETTLE_TIME  = 8;

   typedef struct packed {
      logic [NUM_W-1:0]   number;
      logic [VALUE_W-1:0] value;
      logic               last_of_word;
      logic               section_done;
   } index_entry_type;

   class index_scoreboard;
      logic [WIDTH_W-1:0] width_reg;
      logic               layout_reg;
      logic [15:0]        carry_bits;
      int                 carry_count;
      int                 entries_done;
      index_entry_type    pending[$];
      int                 failures;

      function new();
         width_reg    = RESET_WIDTH;
         layout_reg   = LAYOUT_PADDED;
         carry_bits   = '0;
         carry_count  = 0;
         entries_done = 0;
         failures     = 0;
      endfunction

      function logic [VALUE_W-1:0] low_mask(int n);
         return VALUE_W'((32'h1 << n) - 1);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) begin
            $display("%s", what);
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [WIDTH_W-1:0] data);
         case (idx)
            CSR_ENTRY_WIDTH: width_reg = data;
            CSR_LAYOUT_MODE: layout_reg = data[0];
            default: ;
         endcase
      endfunction

      // Expands one accepted word into the index transactions it should give
      // and returns how many there are.
      function int note_word(logic [WORD_W-1:0] word, logic first);
         int eff_width;
         int total;
         int pos;
         int count;
         int left;
         logic [STREAM_W-1:0] stream;
         index_entry_type ent;
         if (width_reg < WIDTH_W'(MIN_WIDTH)) begin
            eff_width = MIN_WIDTH;
         end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            eff_width = MAX_WIDTH;
         end else begin
            eff_width = int'(width_reg);
         end
         if (first) begin
            carry_bits   = '0;
            carry_count  = 0;
            entries_done = 0;
         end
         if (entries_done >= SECTION_ENTRIES) begin
            return 0;
         end
         if (layout_reg == LAYOUT_PADDED) begin
            carry_bits  = '0;
            carry_count = 0;
         end
         // Leftover bits sit below the new word in one continuous stream.
         stream = ({{VALUE_W{1'b0}}, word} << carry_count)
                  | STREAM_W'(carry_bits & low_mask(carry_count));
         total = carry_count + WORD_W;
         pos   = 0;
         count = 0;
         while (pos + eff_width <= total && entries_done < SECTION_ENTRIES
                && count < LANES) begin
            ent.number       = NUM_W'(entries_done);
            ent.value        = VALUE_W'(stream >> pos) & low_mask(eff_width);
            ent.last_of_word = 1'b0;
            ent.section_done = (entries_done == SECTION_ENTRIES - 1);
            pending.push_back(ent);
            entries_done++;
            pos += eff_width;
            count++;
         end
         if (count > 0) begin
            pending[pending.size() - 1].last_of_word = 1'b1;
         end
         if (layout_reg == LAYOUT_PADDED || entries_done >= SECTION_ENTRIES) begin
            carry_bits  = '0;
            carry_count = 0;
         end else begin
            left = total - pos;
            if (left > VALUE_W) begin
               left = VALUE_W;
            end
            carry_bits  = VALUE_W'(stream >> pos) & low_mask(left);
            carry_count = left;
         end
         return count;
      endfunction

      function void check_entry(index_entry_type got);
         index_entry_type want;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected transaction: number=%0d value=%h last=%b done=%b",
                           got.number, got.value, got.last_of_word, got.section_done));
            return;
         end
         want = pending.pop_front();
         if (got.number !== want.number || got.value !== want.value
             || got.last_of_word !== want.last_of_word
             || got.section_done !== want.section_done) begin
            flag($sformatf({"mismatch: expected number=%0d value=%h last=%b done=%b,",
                            " got number=%0d value=%h last=%b done=%b"},
                           want.number, want.value, want.last_of_word, want.section_done,
                           got.number, got.value, got.last_of_word, got.section_done));
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [WORD_W-1:0]      req_packed_word;
   logic                   req_first_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [NUM_W-1:0]       rsp_entry_number;
   logic [VALUE_W-1:0]     rsp_entry_value;
   logic                   rsp_last_of_word;
   logic                   rsp_section_done;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WIDTH_W-1:0]     csr_wdata;

   index_scoreboard sb;
   int              productive_words = 0;
   int              cycle_count = 0;
   bit              hold_request;

   packed_index_unpacker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_packed_word  (req_packed_word),
      .req_first_word   (req_first_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_number (rsp_entry_number),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_last_of_word (rsp_last_of_word),
      .rsp_section_done (rsp_section_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Configuration, results and words are all observed here so that their
   // order within one edge is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_entry('{rsp_entry_number, rsp_entry_value,
                             rsp_last_of_word, rsp_section_done});
         end
         if (req_valid && req_ready) begin
            if (sb.note_word(req_packed_word, req_first_word) > 0) begin
               productive_words++;
            end
         end
      end
   end

   // The receiver changes its stall pattern every stretch, and once holds off
   // for a long time when asked to.
   initial begin
      int stall_mode;
      int stretch;
      rsp_ready  = 1'b0;
      stall_mode = 0;
      stretch    = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            if (stretch == 0) begin
               stall_mode = $urandom_range(0, 3);
               stretch    = $urandom_range(20, 100);
            end
            stretch--;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_word(logic [WORD_W-1:0] word, logic first);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_packed_word <= word;
      req_first_word  <= first;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [WIDTH_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers change only once every expected transaction is out and any
   // word that gives no result has had time to pass.
   task automatic configure(logic [WIDTH_W-1:0] width, logic layout);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
      write_csr(CSR_ENTRY_WIDTH, width);
      write_csr(CSR_LAYOUT_MODE, {{(WIDTH_W - 1){1'b0}}, layout});
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_phase(int words, bit lead_first, int first_odds);
      int burst_left;
      bit steady;
      logic first;
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < words; k++) begin
         if (k == 0) begin
            first = lead_first;
         end else begin
            first = (first_odds > 0) && ($urandom_range(1, first_odds) == 1);
         end
         send_word(random_word(), first);
         burst_left--;
         if (burst_left == 0) begin
            if (!steady) begin
               pause($urandom_range(0, 6));
            end
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   initial begin
      logic [WIDTH_W-1:0] width;
      int random_start;
      int phase;
      sb              = new();
      hold_request    = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_packed_word = '0;
      req_first_word  = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_ENTRY_WIDTH;
      csr_wdata       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: width 4, padded.
      send_word('0, 1'b1);
      send_word('1, 1'b0);
      send_word(64'h0123_4567_89AB_CDEF, 1'b0);
      send_word(64'hA5A5_5A5A_F00F_0FF0, 1'b0);
      // Spanning at width 5 leaves bits over from every word, four from the first.
      configure(WIDTH_W'(5), LAYOUT_SPAN);
      send_word('1, 1'b1);
      send_word('0, 1'b0);
      send_word('1, 1'b0);
      // The width changes while leftover bits are held.
      configure(WIDTH_W'(7), LAYOUT_SPAN);
      send_word(64'h5555_5555_5555_5555, 1'b0);
      send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      // Padded layout drops the leftover bits.
      configure(WIDTH_W'(7), LAYOUT_PADDED);
      send_word(64'hFEDC_BA98_7654_3210, 1'b0);
      send_word('1, 1'b0);
      // Widths outside 4..16 are clamped.
      configure(WIDTH_W'(3), LAYOUT_SPAN);
      send_word(random_word(), 1'b1);
      send_word(random_word(), 1'b0);
      configure(WIDTH_W'(0), LAYOUT_SPAN);
      send_word(random_word(), 1'b0);
      configure(WIDTH_W'(17), LAYOUT_SPAN);
      send_word('1, 1'b0);
      configure(WIDTH_W'(31), LAYOUT_PADDED);
      send_word(random_word(), 1'b0);
      configure(WIDTH_W'(16), LAYOUT_SPAN);
      send_word(random_word(), 1'b1);
      send_word('1, 1'b0);
      configure(WIDTH_W'(13), LAYOUT_SPAN);
      send_word(random_word(), 1'b0);
      send_word(random_word(), 1'b0);
      send_word(random_word(), 1'b0);

      // A full section at width 4 with four leftover bits carried throughout,
      // followed by words that arrive after the section is complete.
      configure(WIDTH_W'(5), LAYOUT_SPAN);
      send_word(random_word(), 1'b1);
      configure(WIDTH_W'(4), LAYOUT_SPAN);
      run_phase(262, 1'b0, 0);

      random_start = productive_words;
      phase        = 0;
      while (productive_words - random_start < RANDOM_WORDS) begin
         if ($urandom_range(0, 7) == 0) begin
            width = WIDTH_W'($urandom_range(0, 31));
         end else begin
            width = WIDTH_W'($urandom_range(MIN_WIDTH, MAX_WIDTH));
         end
         configure(width, 1'($urandom_range(0, 1)));
         if (phase == 1) begin
            hold_request = 1'b1;
            run_phase(60, 1'b1, 50);
         end else begin
            run_phase($urandom_range(10, 60), 1'($urandom_range(0, 1)), 50);
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
